// File: design/alpha_blend_blit_assert.svh
// Assertion macros for the blit engine.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef ALPHA_BLEND_BLIT_ASSERT_SVH
`define ALPHA_BLEND_BLIT_ASSERT_SVH

// Implication checked on every rising edge outside reset.
`define ABB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Condition that must never be seen outside reset.
`define ABB_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

// File: design/abb_pkg.sv
// Shared types and constants of the blit engine.
// No dependencies.
`default_nettype none

package abb_pkg;

  localparam int unsigned MAX_DIM_DEF   = 4096;
  localparam int unsigned ADDR_BITS_DEF = 24;
  localparam int unsigned QUEUE_DEPTH   = 4;

  localparam int unsigned DIM_W     = 13;  // width, height registers
  localparam int unsigned POS_W     = 12;  // origin registers
  localparam int unsigned PIX_W     = 32;
  localparam int unsigned CH_W      = 8;
  localparam int unsigned CH_NUM    = 4;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 13;
  localparam int unsigned ALPHA_ONE = 256;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEST_WIDTH   = 3'd0,
    REG_SRC_WIDTH    = 3'd1,
    REG_SRC_HEIGHT   = 3'd2,
    REG_POS_X        = 3'd3,
    REG_POS_Y        = 3'd4,
    REG_BLEND_ENABLE = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [DIM_W-1:0] dest_width;
    logic [DIM_W-1:0] src_width;
    logic [DIM_W-1:0] src_height;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic             blend_enable;
  } abb_cfg_t;

endpackage

`default_nettype wire

// File: design/abb_front.sv
// Front end: takes input requests, steps the column and row counters and
// forms the partial address sums and the last flag. Depends on abb_pkg.
`default_nettype none

module abb_front #(
  parameter int unsigned MAX_DIM = abb_pkg::MAX_DIM_DEF
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  abb_pkg::abb_cfg_t   cfg_i,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  wire                 q_full_i,
  output logic                push_o,
  output logic [((($clog2(MAX_DIM) > abb_pkg::POS_W) ? $clog2(MAX_DIM)
                 : abb_pkg::POS_W) + 1)-1:0] xsum_o,
  output logic [((($clog2(MAX_DIM) > abb_pkg::POS_W) ? $clog2(MAX_DIM)
                 : abb_pkg::POS_W) + 1)-1:0] ysum_o,
  output logic                last_o
);

  localparam int unsigned CNT_W = $clog2(MAX_DIM);
  localparam int unsigned SUM_W = ((CNT_W > abb_pkg::POS_W) ? CNT_W : abb_pkg::POS_W) + 1;
  localparam int unsigned CMP_W = ((CNT_W > abb_pkg::DIM_W) ? CNT_W : abb_pkg::DIM_W) + 1;

  logic [CNT_W-1:0] col_q, col_d;
  logic [CNT_W-1:0] row_q, row_d;
  logic [CMP_W-1:0] w_m1, h_m1;
  logic             end_col, end_row;

  // Effective size minus one: zero acts as one, oversize clamps to MAX_DIM.
  function automatic logic [CMP_W-1:0] size_m1(logic [abb_pkg::DIM_W-1:0] v);
    logic [CMP_W-1:0] ve;
    ve = CMP_W'(v);
    if (v == '0) begin
      return '0;
    end else if (ve >= CMP_W'(MAX_DIM)) begin
      return CMP_W'(MAX_DIM - 1);
    end else begin
      return ve - CMP_W'(1);
    end
  endfunction

  assign w_m1    = size_m1(cfg_i.src_width);
  assign h_m1    = size_m1(cfg_i.src_height);
  assign end_col = CMP_W'(col_q) >= w_m1;
  assign end_row = CMP_W'(row_q) >= h_m1;

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;
  assign xsum_o     = SUM_W'(col_q) + SUM_W'(cfg_i.pos_x);
  assign ysum_o     = SUM_W'(row_q) + SUM_W'(cfg_i.pos_y);
  assign last_o     = end_col && end_row;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (push_o) begin
      if (end_col) begin
        col_d = '0;
        row_d = end_row ? '0 : row_q + CNT_W'(1);
      end else begin
        col_d = col_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

`default_nettype wire

// File: design/abb_fifo.sv
// Short flop-based queue between front and back end.
// Depends on nothing but its parameters.
`default_nettype none

module abb_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              push_i,
  input  wire  [WIDTH-1:0] wdata_i,
  input  wire              pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = cnt_q == CNT_W'(DEPTH);
  assign empty_o = cnt_q == '0;
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_comb begin
    wr_ptr_d = do_push ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

// File: design/abb_back.sv
// Back end: two-stage pipe that multiplies out the row address, blends the
// pixel and holds the result for the output. Depends on abb_pkg.
`default_nettype none

module abb_back #(
  parameter int unsigned MAX_DIM   = abb_pkg::MAX_DIM_DEF,
  parameter int unsigned ADDR_BITS = abb_pkg::ADDR_BITS_DEF
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  abb_pkg::abb_cfg_t          cfg_i,
  input  wire                        q_valid_i,
  output logic                       q_pop_o,
  input  wire  [abb_pkg::PIX_W-1:0]  src_pixel_i,
  input  wire  [abb_pkg::PIX_W-1:0]  dst_pixel_i,
  input  wire  [((($clog2(MAX_DIM) > abb_pkg::POS_W) ? $clog2(MAX_DIM)
                 : abb_pkg::POS_W) + 1)-1:0] xsum_i,
  input  wire  [((($clog2(MAX_DIM) > abb_pkg::POS_W) ? $clog2(MAX_DIM)
                 : abb_pkg::POS_W) + 1)-1:0] ysum_i,
  input  wire                        last_i,
  output logic                       s1_valid_o,
  output logic                       out_valid_o,
  input  wire                        out_stall_i,
  output logic [ADDR_BITS-1:0]       dest_address_o,
  output logic [abb_pkg::PIX_W-1:0]  new_pixel_o,
  output logic                       last_o
);

  localparam int unsigned CNT_W  = $clog2(MAX_DIM);
  localparam int unsigned SUM_W  = ((CNT_W > abb_pkg::POS_W) ? CNT_W : abb_pkg::POS_W) + 1;
  localparam int unsigned PROD_W = SUM_W + abb_pkg::DIM_W;
  localparam int unsigned EXT_W  = (PROD_W + 1 > ADDR_BITS) ? PROD_W + 1 : ADDR_BITS;
  localparam int unsigned ACC_W  = 2 * abb_pkg::CH_W;
  localparam int unsigned IA_W   = abb_pkg::CH_W + 1;

  // Stage 1 registers
  logic                      s1_valid_q;
  logic [PROD_W-1:0]         prod_q;
  logic [SUM_W-1:0]          xsum_q;
  logic [abb_pkg::PIX_W-1:0] pix_q;
  logic                      s1_last_q;

  // Output stage registers
  logic                      out_valid_q;
  logic [ADDR_BITS-1:0]      addr_q;
  logic [abb_pkg::PIX_W-1:0] out_pix_q;
  logic                      out_last_q;

  logic              s1_ready, s2_ready;
  logic [EXT_W-1:0]  addr_sum;

  // Per channel floor((s*a + d*(256-a))/256); the sum never exceeds 16 bits.
  function automatic logic [abb_pkg::PIX_W-1:0] blend_px(
    logic [abb_pkg::PIX_W-1:0] s,
    logic [abb_pkg::PIX_W-1:0] d
  );
    logic [abb_pkg::CH_W-1:0]  a;
    logic [IA_W-1:0]           ia;
    logic [ACC_W-1:0]          acc;
    logic [abb_pkg::PIX_W-1:0] r;
    a  = s[abb_pkg::PIX_W-1 -: abb_pkg::CH_W];
    ia = IA_W'(abb_pkg::ALPHA_ONE) - IA_W'(a);
    r  = '0;
    for (int i = 0; i < abb_pkg::CH_NUM; i++) begin
      acc = ACC_W'(ACC_W'(s[abb_pkg::CH_W*i +: abb_pkg::CH_W]) * ACC_W'(a))
          + ACC_W'(ACC_W'(d[abb_pkg::CH_W*i +: abb_pkg::CH_W]) * ACC_W'(ia));
      r[abb_pkg::CH_W*i +: abb_pkg::CH_W] = acc[ACC_W-1 -: abb_pkg::CH_W];
    end
    return r;
  endfunction

  assign s2_ready = !out_valid_q || !out_stall_i;
  assign s1_ready = !s1_valid_q || s2_ready;
  assign q_pop_o  = s1_ready && q_valid_i;
  assign addr_sum = EXT_W'(prod_q) + EXT_W'(xsum_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= q_valid_i;
      end
      if (s2_ready) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      prod_q    <= PROD_W'(ysum_i) * PROD_W'(cfg_i.dest_width);
      xsum_q    <= xsum_i;
      pix_q     <= cfg_i.blend_enable ? blend_px(src_pixel_i, dst_pixel_i) : src_pixel_i;
      s1_last_q <= last_i;
    end
    if (s2_ready && s1_valid_q) begin
      addr_q     <= addr_sum[ADDR_BITS-1:0];
      out_pix_q  <= pix_q;
      out_last_q <= s1_last_q;
    end
  end

  assign s1_valid_o     = s1_valid_q;
  assign out_valid_o    = out_valid_q;
  assign dest_address_o = addr_q;
  assign new_pixel_o    = out_pix_q;
  assign last_o         = out_last_q;

endmodule

`default_nettype wire

// File: design/alpha_blend_blit.sv
// Top level of the ARGB8888 rectangle blit engine: configuration registers,
// front end, request queue and back end. Depends on abb_pkg and the
// abb_front, abb_fifo and abb_back modules.
`default_nettype none
`include "alpha_blend_blit_assert.svh"

// The engine takes one source pixel per request, in raster order over the
// rectangle, together with the destination pixel now held at its target
// location, and returns one write request per pixel: the destination index
// (pos_y+row)*dest_width + column + pos_x, wrapped to ADDR_BITS bits, the
// new pixel and a flag on the last pixel of the rectangle. With
// blend_enable clear the new pixel is the source pixel; with it set every
// channel, alpha included, is floor((s*a + d*(256-a))/256) with a the
// source alpha. A width or height of zero counts as one and anything above
// MAX_DIM as MAX_DIM. While the output is not stalled the engine sustains
// one pixel per clock: the front end steps its counters on each accepted
// request and the back end is a fully pipelined multiply stage followed by
// the output register. A taken request lands in the queue, passes the
// multiply and blend stage and then reaches the output register. Up to
// four requests wait in the queue, so the input keeps flowing while the
// output is stalled until the queue is full.
// Write configuration only while the engine is idle; the column and row
// counters restart at the origin after the last pixel of a rectangle.

module alpha_blend_blit #(
  parameter int unsigned MAX_DIM   = abb_pkg::MAX_DIM_DEF,
  parameter int unsigned ADDR_BITS = abb_pkg::ADDR_BITS_DEF
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  // configuration write port
  input  wire                            cfg_we_i,
  input  wire  [abb_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire  [abb_pkg::CFG_DAT_W-1:0]  cfg_data_i,
  // input channel
  input  wire                            in_valid_i,
  output logic                           in_stall_o,
  input  wire  [abb_pkg::PIX_W-1:0]      src_pixel_i,
  input  wire  [abb_pkg::PIX_W-1:0]      dst_pixel_i,
  // output channel
  output logic                           out_valid_o,
  input  wire                            out_stall_i,
  output logic [ADDR_BITS-1:0]           dest_address_o,
  output logic [abb_pkg::PIX_W-1:0]      new_pixel_o,
  output logic                           last_o
);

  localparam int unsigned CNT_W = $clog2(MAX_DIM);
  localparam int unsigned SUM_W = ((CNT_W > abb_pkg::POS_W) ? CNT_W : abb_pkg::POS_W) + 1;
  localparam int unsigned ENT_W = 2 * abb_pkg::PIX_W + 2 * SUM_W + 1;

  abb_pkg::abb_cfg_t cfg_q;

  logic             f_push, q_full, q_empty, q_pop, s1_valid;
  logic [SUM_W-1:0] f_xsum, f_ysum, q_xsum, q_ysum;
  logic             f_last, q_last;
  logic [ENT_W-1:0] q_wdata, q_rdata;
  logic [abb_pkg::PIX_W-1:0] q_src, q_dst;

  // Configuration registers: write by index, ignore indexes past the list.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dest_width   <= abb_pkg::DIM_W'(1);
      cfg_q.src_width    <= abb_pkg::DIM_W'(1);
      cfg_q.src_height   <= abb_pkg::DIM_W'(1);
      cfg_q.pos_x        <= '0;
      cfg_q.pos_y        <= '0;
      cfg_q.blend_enable <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        abb_pkg::REG_DEST_WIDTH:   cfg_q.dest_width   <= cfg_data_i[abb_pkg::DIM_W-1:0];
        abb_pkg::REG_SRC_WIDTH:    cfg_q.src_width    <= cfg_data_i[abb_pkg::DIM_W-1:0];
        abb_pkg::REG_SRC_HEIGHT:   cfg_q.src_height   <= cfg_data_i[abb_pkg::DIM_W-1:0];
        abb_pkg::REG_POS_X:        cfg_q.pos_x        <= cfg_data_i[abb_pkg::POS_W-1:0];
        abb_pkg::REG_POS_Y:        cfg_q.pos_y        <= cfg_data_i[abb_pkg::POS_W-1:0];
        abb_pkg::REG_BLEND_ENABLE: cfg_q.blend_enable <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // Front end: take the request, advance the counters, classify the pixel.
  abb_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .q_full_i   (q_full),
    .push_o     (f_push),
    .xsum_o     (f_xsum),
    .ysum_o     (f_ysum),
    .last_o     (f_last)
  );

  // Queue: decouple the front end from output back-pressure.
  assign q_wdata = {src_pixel_i, dst_pixel_i, f_xsum, f_ysum, f_last};
  assign {q_src, q_dst, q_xsum, q_ysum, q_last} = q_rdata;

  abb_fifo #(
    .WIDTH (ENT_W),
    .DEPTH (abb_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .wdata_i (q_wdata),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // Back end: multiply out the row, blend, hold the result until taken.
  abb_back #(
    .MAX_DIM   (MAX_DIM),
    .ADDR_BITS (ADDR_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .q_valid_i      (!q_empty),
    .q_pop_o        (q_pop),
    .src_pixel_i    (q_src),
    .dst_pixel_i    (q_dst),
    .xsum_i         (q_xsum),
    .ysum_i         (q_ysum),
    .last_i         (q_last),
    .s1_valid_o     (s1_valid),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .dest_address_o (dest_address_o),
    .new_pixel_o    (new_pixel_o),
    .last_o         (last_o)
  );

  // Checks on the queue and the back-end pipe.
  `ABB_ASSERT_NEVER(a_pop_empty, q_pop && q_empty, "queue popped while empty")
  `ABB_ASSERT_NEVER(a_push_full, f_push && q_full, "queue pushed while full")
  `ABB_ASSERT_IMP(a_hold_pipe, out_valid_o && out_stall_i && s1_valid, !q_pop, "queue popped while the back end is blocked")
  `ABB_ASSERT_IMP(a_stall_full, in_stall_o, q_full, "input stalled with room in the queue")

endmodule

`default_nettype wire

// File: bench/tb.sv
// Self-checking bench for the alpha_blend_blit rectangle blit engine.
// Depends on abb_pkg and the design sources; predicts every write request
// in the bench itself and drives random gaps and stalls on both channels.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import abb_pkg::*;

  localparam int unsigned ADDR_W       = ADDR_BITS_DEF;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned RANDOM_ITEMS = 1300;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned MAX_WAIT     = 8;
  localparam int unsigned N_DIR        = 32;

  typedef longint unsigned u64_t;

  // One write request as the engine emits it.
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  pixel;
    logic              last;
  } pix_write_t;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_e;

  // A directed row is either a register write or a pixel request. Rows with
  // typed set carry their own expected write; the rest go to the predictor.
  typedef struct packed {
    row_kind_e            kind;
    cfg_reg_e             regi;
    logic [CFG_DAT_W-1:0] value;
    logic [PIX_W-1:0]     src;
    logic [PIX_W-1:0]     dst;
    logic                 typed;
    pix_write_t           want;
  } dir_row_t;

  localparam dir_row_t DIRECTED [N_DIR] = '{
    // Reset settings: 1x1 copy at the origin, every request is the last one.
    '{ROW_ITEM, REG_DEST_WIDTH, 13'd0, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1,
      '{24'h0, 32'hFFFF_FFFF, 1'b1}},
    '{ROW_ITEM, REG_DEST_WIDTH, 13'd0, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1,
      '{24'h0, 32'h0000_0000, 1'b1}},
    // Blend with opaque and fully transparent sources, then partial alphas.
    '{ROW_REG,  REG_BLEND_ENABLE, 13'd1, 32'h0, 32'h0, 1'b0, '0},
    '{ROW_ITEM, REG_DEST_WIDTH, 13'd0, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1,
      '{24'h0, 32'hFEFE_FEFE, 1'b1}},
    '{ROW_ITEM, REG_DEST_WIDTH, 13'd0, 32'h00FF_FFFF, 32'h1234_5678, 1'b1,
      '{24'h0, 32'h1234_5678, 1'b1}},
    '{ROW_ITEM, REG_DEST_WIDTH, 13'd0, 32'h80FF_00FF, 32'h00FF_00FF, 1'b0, '0},
    '{ROW_ITEM, REG_DEST_WIDTH, 13'd0, 32'h01FF_00FF, 32'hFF00_FF00, 1'b0, '0},
    // Zero-sized rectangle at the far corner of the widest surface: the
    // address overflows and wraps.
    '{ROW_REG,  REG_SRC_WIDTH,  13'd0,    32'h0, 32'h0, 1'b0, '0},
    '{ROW_REG,  REG_SRC_HEIGHT, 13'd0,    32'h0, 32'h0, 1'b0, '0},
    '{ROW_REG,  REG_POS_X,      13'd4095, 32'h0, 32'h0, 1'b0, '0},
    '{ROW_REG,  REG_POS_Y,      13'd4095, 32'h0, 32'h0, 1'b0, '0},
    '{ROW_REG,  REG_DEST_WIDTH, 13'd8191, 32'h0, 32'h0, 1'b0, '0},
    '{ROW_ITEM, REG_DEST_WIDTH, 13'd0, 32'h1357_9BDF, 32'h2468_ACE0, 1'b0, '0},
    '{ROW_ITEM, REG_DEST_WIDTH, 13'd0, 32'hFE80_8182, 32'h55AA_55AA, 1'b0, '0},
    // Zero destination width drops the row term from the address.
    '{ROW_REG,  REG_DEST_WIDTH, 13'd0, 32'h0, 32'h0, 1'b0, '0},
    '{ROW_ITEM, REG_DEST_WIDTH, 13'd0, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b0, '0},
    // Oversized line in copy mode, then shrink it with the column already
    // past the new end: that request must close the line.
    '{ROW_REG,  REG_BLEND_ENABLE, 13'd0,    32'h0, 32'h0, 1'b0, '0},
    '{ROW_REG,  REG_POS_X,        13'd0,    32'h0, 32'h0, 1'b0, '0},
    '{ROW_REG,  REG_POS_Y,        13'd0,    32'h0, 32'h0, 1'b0, '0},
    '{ROW_REG,  REG_DEST_WIDTH,   13'd4096, 32'h0, 32'h0, 1'b0, '0},
    '{ROW_REG,  REG_SRC_WIDTH,    13'd8191, 32'h0, 32'h0, 1'b0, '0},
    '{ROW_REG,  REG_SRC_HEIGHT,   13'd2,    32'h0, 32'h0, 1'b0, '0},
    '{ROW_ITEM, REG_DEST_WIDTH, 13'd0, 32'h1111_1111, 32'hEEEE_EEEE, 1'b1,
      '{24'd0, 32'h1111_1111, 1'b0}},
    '{ROW_ITEM, REG_DEST_WIDTH, 13'd0, 32'h2222_2222, 32'hDDDD_DDDD, 1'b1,
      '{24'd1, 32'h2222_2222, 1'b0}},
    '{ROW_ITEM, REG_DEST_WIDTH, 13'd0, 32'h3333_3333, 32'hCCCC_CCCC, 1'b1,
      '{24'd2, 32'h3333_3333, 1'b0}},
    '{ROW_ITEM, REG_DEST_WIDTH, 13'd0, 32'h4444_4444, 32'hBBBB_BBBB, 1'b1,
      '{24'd3, 32'h4444_4444, 1'b0}},
    '{ROW_ITEM, REG_DEST_WIDTH, 13'd0, 32'h5555_5555, 32'hAAAA_AAAA, 1'b1,
      '{24'd4, 32'h5555_5555, 1'b0}},
    '{ROW_REG,  REG_SRC_WIDTH,  13'd3, 32'h0, 32'h0, 1'b0, '0},
    '{ROW_ITEM, REG_DEST_WIDTH, 13'd0, 32'h6666_6666, 32'h9999_9999, 1'b0, '0},
    '{ROW_ITEM, REG_DEST_WIDTH, 13'd0, 32'h7777_7777, 32'h8888_8888, 1'b0, '0},
    '{ROW_ITEM, REG_DEST_WIDTH, 13'd0, 32'h8888_8888, 32'h7777_7777, 1'b0, '0},
    '{ROW_ITEM, REG_DEST_WIDTH, 13'd0, 32'h9999_9999, 32'h6666_6666, 1'b0, '0}
  };

  // Stimulus side of the engine.
  logic                 clk         = 1'b0;
  logic                 rst_n       = 1'b0;
  logic                 cfg_we      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index   = '0;
  logic [CFG_DAT_W-1:0] cfg_data    = '0;
  logic                 in_valid    = 1'b0;
  logic [PIX_W-1:0]     src_pixel   = '0;
  logic [PIX_W-1:0]     dst_pixel   = '0;
  logic                 out_stall   = 1'b0;
  wire                  in_stall;
  wire                  out_valid;
  wire  [ADDR_W-1:0]    dest_address;
  wire  [PIX_W-1:0]     new_pixel;
  wire                  last_flag;

  // Bench copy of the registers and the raster counters.
  abb_cfg_t             surface_regs;
  logic [POS_W-1:0]     col_pos;
  logic [POS_W-1:0]     row_pos;

  pix_write_t           pending_writes[$];
  bit                   steady_flow = 1'b0;   // no gaps and no stalls while set
  int unsigned          cycle_count = 0;
  int unsigned          n_sent      = 0;
  int unsigned          n_checked   = 0;
  int unsigned          n_errors    = 0;
  int unsigned          n_reg_writes = 0;
  int unsigned          n_phases    = 0;
  int unsigned          n_line_items = 0;

  alpha_blend_blit dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .src_pixel_i    (src_pixel),
    .dst_pixel_i    (dst_pixel),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .dest_address_o (dest_address),
    .new_pixel_o    (new_pixel),
    .last_o         (last_flag)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop if the engine hangs or a handshake never completes.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout at cycle %0d with %0d writes outstanding", cycle_count,
               pending_writes.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Zero or oversized dimensions are taken as 1 and MAX_DIM.
  function automatic int unsigned clamp_dim(logic [DIM_W-1:0] v);
    if (v == '0) return 1;
    if (32'(v) > MAX_DIM_DEF) return MAX_DIM_DEF;
    return 32'(v);
  endfunction

  // Per channel, alpha included: floor((s*a + d*(256-a)) / 256).
  function automatic logic [PIX_W-1:0] blend_over(logic [PIX_W-1:0] s,
                                                   logic [PIX_W-1:0] d);
    int unsigned      a;
    int unsigned      mix;
    logic [PIX_W-1:0] res;
    a   = 32'(s[PIX_W-1 -: CH_W]);
    res = '0;
    for (int ch = 0; ch < CH_NUM; ch++) begin
      mix = (32'(s[ch*CH_W +: CH_W]) * a + 32'(d[ch*CH_W +: CH_W]) * (ALPHA_ONE - a)) >> 8;
      res[ch*CH_W +: CH_W] = mix[CH_W-1:0];
    end
    return res;
  endfunction

  // Work out the write for one accepted request and advance the raster.
  // A counter already at or past its end (after a shrink) closes the line.
  function automatic pix_write_t next_write(logic [PIX_W-1:0] s, logic [PIX_W-1:0] d);
    pix_write_t  w;
    int unsigned wid;
    int unsigned hgt;
    logic        end_col;
    logic        end_row;
    u64_t        lin;
    wid     = clamp_dim(surface_regs.src_width);
    hgt     = clamp_dim(surface_regs.src_height);
    end_col = 32'(col_pos) >= wid - 1;
    end_row = 32'(row_pos) >= hgt - 1;
    lin = (u64_t'(surface_regs.pos_y) + u64_t'(row_pos)) * u64_t'(surface_regs.dest_width)
        + u64_t'(col_pos) + u64_t'(surface_regs.pos_x);
    w.addr  = lin[ADDR_W-1:0];
    w.pixel = surface_regs.blend_enable ? blend_over(s, d) : s;
    w.last  = end_col && end_row;
    if (end_col) begin
      col_pos = '0;
      row_pos = end_row ? '0 : row_pos + 1'b1;
    end else begin
      col_pos = col_pos + 1'b1;
    end
    return w;
  endfunction

  function automatic int unsigned pick_wait();
    return steady_flow ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  function automatic logic [PIX_W-1:0] draw_pixel();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Mostly small sizes; now and then zero, the maximum or beyond it.
  function automatic logic [CFG_DAT_W-1:0] draw_dim(int unsigned hi);
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return CFG_DAT_W'(MAX_DIM_DEF);
      2:       return CFG_DAT_W'($urandom_range(MAX_DIM_DEF + 1, 8191));
      default: return CFG_DAT_W'($urandom_range(1, hi));
    endcase
  endfunction

  function automatic logic [CFG_DAT_W-1:0] draw_pos();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return CFG_DAT_W'(4095);
      default: return CFG_DAT_W'($urandom_range(0, 4095));
    endcase
  endfunction

  function automatic logic [CFG_DAT_W-1:0] draw_dest_width();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return CFG_DAT_W'(1);
      2:       return CFG_DAT_W'(MAX_DIM_DEF);
      3:       return '1;
      default: return CFG_DAT_W'($urandom_range(1, MAX_DIM_DEF));
    endcase
  endfunction

  // Write one register once the engine has drained. Drop valid first so no
  // request is in flight across the write; cfg_we is left high and lowered
  // by the next request.
  task automatic write_reg(cfg_reg_e idx, logic [CFG_DAT_W-1:0] val);
    in_valid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_DEST_WIDTH:   surface_regs.dest_width   = val[DIM_W-1:0];
      REG_SRC_WIDTH:    surface_regs.src_width    = val[DIM_W-1:0];
      REG_SRC_HEIGHT:   surface_regs.src_height   = val[DIM_W-1:0];
      REG_POS_X:        surface_regs.pos_x        = val[POS_W-1:0];
      REG_POS_Y:        surface_regs.pos_y        = val[POS_W-1:0];
      REG_BLEND_ENABLE: surface_regs.blend_enable = val[0];
      default: ;
    endcase
    n_reg_writes++;
  endtask

  // Offer one pixel request after a random gap and hold it until taken.
  // Returns at the accepting edge with valid still high, so a request that
  // follows without a gap keeps the line up.
  task automatic send_pixel(logic [PIX_W-1:0] s, logic [PIX_W-1:0] d,
                            logic typed, pix_write_t want);
    int unsigned gap;
    pix_write_t  model;
    gap = pick_wait();
    cfg_we <= 1'b0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    src_pixel <= s;
    dst_pixel <= d;
    do @(posedge clk); while (in_stall !== 1'b0);
    model = next_write(s, d);
    pending_writes.push_back(typed ? want : model);
    n_sent++;
  endtask

  // Output side: stall for a random stretch before each write, then take it
  // and compare field by field with the oldest expected write.
  initial begin : check_writes
    int unsigned hold;
    pix_write_t  want;
    wait (rst_n === 1'b1);
    forever begin
      hold = pick_wait();
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (out_valid !== 1'b1);
      if (pending_writes.size() == 0) begin
        $display("%0t: unexpected write: addr %h pixel %h last %b", $time,
                 dest_address, new_pixel, last_flag);
        n_errors++;
      end else begin
        want = pending_writes.pop_front();
        if (dest_address !== want.addr) begin
          $display("%0t: address mismatch: expected %h actual %h", $time,
                   want.addr, dest_address);
          n_errors++;
        end
        if (new_pixel !== want.pixel) begin
          $display("%0t: pixel mismatch: expected %h actual %h", $time,
                   want.pixel, new_pixel);
          n_errors++;
        end
        if (last_flag !== want.last) begin
          $display("%0t: last flag mismatch: expected %b actual %b", $time,
                   want.last, last_flag);
          n_errors++;
        end
        n_checked++;
      end
    end
  end

  initial begin : stimulus
    int unsigned      n_dir;
    int unsigned      count;
    int unsigned      area;
    logic [PIX_W-1:0] s;
    surface_regs            = '0;
    surface_regs.dest_width = DIM_W'(1);
    surface_regs.src_width  = DIM_W'(1);
    surface_regs.src_height = DIM_W'(1);
    col_pos = '0;
    row_pos = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table.
    for (int i = 0; i < N_DIR; i++) begin
      if (DIRECTED[i].kind == ROW_REG)
        write_reg(DIRECTED[i].regi, DIRECTED[i].value);
      else
        send_pixel(DIRECTED[i].src, DIRECTED[i].dst, DIRECTED[i].typed, DIRECTED[i].want);
    end
    n_dir = n_sent;

    // Random phases: new settings, then mostly whole rectangles, with some
    // cut short so the next phase starts mid-blit.
    while (n_sent - n_dir < RANDOM_ITEMS) begin
      n_phases++;
      steady_flow = ($urandom_range(0, 3) == 0);
      if (n_phases == 12) begin
        // Oversized line: width clamps to MAX_DIM, height of zero; run a
        // short stretch of it.
        write_reg(REG_SRC_WIDTH, CFG_DAT_W'($urandom_range(MAX_DIM_DEF + 1, 8191)));
        write_reg(REG_SRC_HEIGHT, '0);
        write_reg(REG_DEST_WIDTH, draw_dest_width());
        write_reg(REG_POS_X, draw_pos());
        write_reg(REG_POS_Y, draw_pos());
        write_reg(REG_BLEND_ENABLE, CFG_DAT_W'($urandom_range(0, 1)));
        count = $urandom_range(1, 40);
        n_line_items += count;
      end else begin
        if ($urandom_range(0, 3) != 0) write_reg(REG_DEST_WIDTH, draw_dest_width());
        if ($urandom_range(0, 3) != 0) write_reg(REG_SRC_WIDTH, draw_dim(12));
        if ($urandom_range(0, 3) != 0) write_reg(REG_SRC_HEIGHT, draw_dim(6));
        if ($urandom_range(0, 3) != 0) write_reg(REG_POS_X, draw_pos());
        if ($urandom_range(0, 3) != 0) write_reg(REG_POS_Y, draw_pos());
        if ($urandom_range(0, 3) != 0)
          write_reg(REG_BLEND_ENABLE, CFG_DAT_W'($urandom_range(0, 1)));
        area = clamp_dim(surface_regs.src_width) * clamp_dim(surface_regs.src_height);
        if (area > 200)
          count = $urandom_range(1, 40);
        else if ($urandom_range(0, 4) == 0)
          count = $urandom_range(1, area);
        else
          count = area;
      end
      repeat (count) begin
        s = draw_pixel();
        case ($urandom_range(0, 3))
          0:       s[PIX_W-1 -: CH_W] = '0;
          1:       s[PIX_W-1 -: CH_W] = '1;
          default: ;
        endcase
        send_pixel(s, draw_pixel(), 1'b0, '0);
      end
    end

    // Drop valid, wait for the last writes and give stray ones time to show.
    in_valid <= 1'b0;
    cfg_we   <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d pixel requests (%0d directed, %0d on an oversized line)",
             n_sent, n_dir, n_line_items);
    $display("Checked %0d writes over %0d register writes in %0d random phases",
             n_checked, n_reg_writes, n_phases);
    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
